// ===== sv/skin_region_box_centroid_defines.svh =====
// Assertion macros for the skin region box and centroid block.
`ifndef SKIN_REGION_BOX_CENTROID_DEFINES_SVH
`define SKIN_REGION_BOX_CENTROID_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while in reset
`define SRBC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while in reset
`define SRBC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SRBC_ASSERT_NOW(label, ante, cons, msg)
`define SRBC_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== sv/srbc_pkg.sv =====
// Shared types, constants and functions for the skin region box and centroid block.
package srbc_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int MAX_PIXELS_DEF = 65535;

    localparam int POS_W   = 12;
    localparam int COLOR_W = 8;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    // register map indexes (byte address / 4)
    localparam logic [2:0] REG_SAMPLE_COUNT = 3'd0;
    localparam logic [2:0] REG_MISS_LIMIT   = 3'd1;
    localparam logic [2:0] REG_RED_MIN      = 3'd2;
    localparam logic [2:0] REG_GREEN_MIN    = 3'd3;
    localparam logic [2:0] REG_BLUE_MIN     = 3'd4;
    localparam logic [2:0] REG_RED_MARGIN   = 3'd5;

    localparam logic [15:0] SAMPLE_COUNT_RST = 16'd2000;
    localparam logic [7:0]  MISS_LIMIT_RST   = 8'd10;
    localparam logic [7:0]  RED_MIN_RST      = 8'd95;
    localparam logic [7:0]  GREEN_MIN_RST    = 8'd40;
    localparam logic [7:0]  BLUE_MIN_RST     = 8'd20;
    localparam logic [7:0]  RED_MARGIN_RST   = 8'd15;

    // list phases
    localparam logic [1:0] PH_SAMPLING = 2'd0;
    localparam logic [1:0] PH_TRACKING = 2'd1;
    localparam logic [1:0] PH_STOPPED  = 2'd2;
    localparam logic [1:0] PH_REJECTED = 2'd3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef struct packed {
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
        logic               last_pixel;
    } pix_t;

    typedef struct packed {
        logic               hand_found;
        logic [POS_W-1:0]   box_x;
        logic [POS_W-1:0]   box_y;
        logic [POS_W-1:0]   box_width;
        logic [POS_W-1:0]   box_height;
        logic [POS_W-1:0]   center_x;
        logic [POS_W-1:0]   center_y;
        logic [COLOR_W-1:0] mean_blue;
        logic [COLOR_W-1:0] mean_green;
        logic [COLOR_W-1:0] mean_red;
    } res_t;

    typedef struct packed {
        logic [15:0] sample_count;
        logic [7:0]  miss_limit;
        logic [7:0]  red_min;
        logic [7:0]  green_min;
        logic [7:0]  blue_min;
        logic [7:0]  red_margin;
    } cfg_t;

    // classified pixel as held in the queue
    typedef struct packed {
        pix_t pix;
        logic skin;
    } qitem_t;

    typedef struct packed {
        logic [QPTR_W:0] count;
        logic            full;
        logic            empty;
    } qstat_t;

    // RGB skin rule, all bounds strict
    function automatic logic is_skin(cfg_t c, logic [COLOR_W-1:0] b,
                                     logic [COLOR_W-1:0] g, logic [COLOR_W-1:0] r);
        logic [COLOR_W:0] g_m;
        logic [COLOR_W:0] b_m;
        g_m = {1'b0, g} + {1'b0, c.red_margin};
        b_m = {1'b0, b} + {1'b0, c.red_margin};
        return (r > c.red_min) && (g > c.green_min) && (b > c.blue_min) &&
               ({1'b0, r} > g_m) && ({1'b0, r} > b_m);
    endfunction

endpackage

// ===== sv/srbc_pix_if.sv =====
// Pixel and result channel interfaces.
interface srbc_pix_if import srbc_pkg::*; ();
    logic valid;
    logic ready;
    pix_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface srbc_res_if import srbc_pkg::*; ();
    logic valid;
    logic ready;
    res_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/srbc_front.sv =====
// Front end: takes pixel items, classifies them against the skin rule.
module srbc_front import srbc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    srbc_pix_if.sink    pix,
    input  qstat_t      qstat,
    output logic        push,
    output qitem_t      push_item
);

    logic   valid_reg;
    logic   valid_next;
    qitem_t item_reg;
    logic   take;

    // stage drains into the queue whenever there is room
    assign push      = valid_reg && !qstat.full;
    assign push_item = item_reg;
    assign pix.ready = !valid_reg || !qstat.full;
    assign take      = pix.valid && pix.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload with its skin flag
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.pix  <= pix.data;
            item_reg.skin <= is_skin(cfg, pix.data.blue, pix.data.green, pix.data.red);
        end
    end

endmodule

// ===== sv/srbc_fifo.sv =====
// Short queue between the front and back ends.
module srbc_fifo import srbc_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  qitem_t push_item,
    input  logic   pop,
    output qitem_t pop_item,
    output qstat_t stat
);

    qitem_t            entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    assign stat.count = count_reg;
    assign stat.full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign pop_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== sv/srbc_div.sv =====
// Restoring divider, one quotient bit per cycle.
module srbc_div #(
    parameter int DIVIDEND_W = 28,
    parameter int DIVISOR_W  = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] dq_reg;
    logic [DIVISOR_W-1:0]  dvs_reg;
    logic [DIVISOR_W:0]    rem_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [DIVISOR_W+1:0]  rem_sh;
    logic [DIVISOR_W+1:0]  rem_sub;

    assign done     = done_reg;
    assign quotient = dq_reg;

    // one trial subtraction per cycle
    always_comb
    begin
        rem_sh  = {rem_reg, dq_reg[DIVIDEND_W-1]};
        rem_sub = rem_sh - {2'b00, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            dq_reg   <= '0;
            dvs_reg  <= '0;
            rem_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIVIDEND_W);
                dq_reg   <= dividend;
                dvs_reg  <= divisor;
                rem_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (!rem_sub[DIVISOR_W+1])
                begin
                    rem_reg <= rem_sub[DIVISOR_W:0];
                    dq_reg  <= {dq_reg[DIVIDEND_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh[DIVISOR_W:0];
                    dq_reg  <= {dq_reg[DIVIDEND_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== sv/srbc_back.sv =====
// Back end: accumulates the list, runs the divisions and emits the result item.
module srbc_back import srbc_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    input  qstat_t       qstat,
    input  qitem_t       item,
    output logic         pop,
    srbc_res_if.source   res
);

    localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
    localparam int CSUM_W = COLOR_W + CNT_W;
    localparam int DIV_W  = COORD_BITS + CNT_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PIXELS);

    // sequencer codes
    localparam logic [1:0] SQ_RUN  = 2'd0;
    localparam logic [1:0] SQ_DIV  = 2'd1;
    localparam logic [1:0] SQ_EMIT = 2'd2;

    // division slots
    localparam logic [2:0] OP_BLUE  = 3'd0;
    localparam logic [2:0] OP_GREEN = 3'd1;
    localparam logic [2:0] OP_RED   = 3'd2;
    localparam logic [2:0] OP_CX    = 3'd3;
    localparam logic [2:0] OP_CY    = 3'd4;

    logic [1:0]            sq_reg, sq_next;
    logic [2:0]            op_reg, op_next;
    logic                  emit_reg, emit_next;
    logic [1:0]            phase_reg, phase_next;
    logic [CNT_W-1:0]      seen_reg, seen_next;
    logic [CSUM_W-1:0]     csum_reg [3];
    logic [CSUM_W-1:0]     csum_next [3];
    logic [7:0]            miss_reg, miss_next;
    logic [COORD_BITS-1:0] min_x_reg, min_x_next, min_y_reg, min_y_next;
    logic [COORD_BITS-1:0] max_x_reg, max_x_next, max_y_reg, max_y_next;
    logic [DIV_W-1:0]      psx_reg, psx_next, psy_reg, psy_next;
    logic [CNT_W-1:0]      rc_reg, rc_next;
    logic [COLOR_W-1:0]    mean_reg [3];
    logic [COLOR_W-1:0]    mean_next [3];
    logic [POS_W-1:0]      cx_reg, cx_next, cy_reg, cy_next;
    logic                  out_valid_reg, out_valid_next;
    res_t                  out_reg, out_next;

    logic                  div_start;
    logic [DIV_W-1:0]      div_a;
    logic [CNT_W-1:0]      div_b;
    logic                  div_done;
    logic [DIV_W-1:0]      div_q;

    logic [COORD_BITS-1:0] px, py;
    logic                  add_en;
    logic                  samp_end;
    logic                  found;
    logic                  mean_skin;

    srbc_div #(
        .DIVIDEND_W (DIV_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    assign px        = COORD_BITS'(item.pix.pos_x);
    assign py        = COORD_BITS'(item.pix.pos_y);
    assign res.valid = out_valid_reg;
    assign res.data  = out_reg;
    assign found     = (phase_reg != PH_REJECTED) && (rc_reg != '0);
    assign mean_skin = is_skin(cfg, mean_reg[0], mean_reg[1], COLOR_W'(div_q));

    // sequencer and list state
    always_comb
    begin
        sq_next    = sq_reg;
        op_next    = op_reg;
        emit_next  = emit_reg;
        phase_next = phase_reg;
        seen_next  = seen_reg;
        miss_next  = miss_reg;
        min_x_next = min_x_reg;
        min_y_next = min_y_reg;
        max_x_next = max_x_reg;
        max_y_next = max_y_reg;
        psx_next   = psx_reg;
        psy_next   = psy_reg;
        rc_next    = rc_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        for (int i = 0; i < 3; i++)
        begin
            csum_next[i] = csum_reg[i];
            mean_next[i] = mean_reg[i];
        end
        out_valid_next = out_valid_reg && !res.ready;
        out_next       = out_reg;
        pop            = 1'b0;
        add_en         = 1'b0;
        samp_end       = 1'b0;
        div_start      = 1'b0;
        div_a          = '0;
        div_b          = '0;

        case (sq_reg)
            SQ_RUN:
            begin
                if (!qstat.empty)
                begin
                    pop       = 1'b1;
                    emit_next = item.pix.last_pixel;
                    case (phase_reg)
                        PH_SAMPLING:
                        begin
                            csum_next[0] = csum_reg[0] + CSUM_W'(item.pix.blue);
                            csum_next[1] = csum_reg[1] + CSUM_W'(item.pix.green);
                            csum_next[2] = csum_reg[2] + CSUM_W'(item.pix.red);
                            seen_next    = seen_reg + 1'b1;
                            add_en       = 1'b1;
                            samp_end     = (32'(seen_next) >= 32'(cfg.sample_count)) ||
                                           (seen_next >= MAX_CNT) || item.pix.last_pixel;
                        end
                        PH_TRACKING:
                        begin
                            if (item.skin)
                            begin
                                miss_next = '0;
                                add_en    = 1'b1;
                            end
                            else if ((9'(miss_reg) + 9'd1) >= 9'(cfg.miss_limit))
                            begin
                                phase_next = PH_STOPPED;
                            end
                            else
                            begin
                                miss_next = miss_reg + 1'b1;
                                add_en    = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase

                    // region update, saturating at the pixel limit
                    if (add_en && (rc_reg < MAX_CNT))
                    begin
                        if (px < min_x_reg) min_x_next = px;
                        if (px > max_x_reg) max_x_next = px;
                        if (py < min_y_reg) min_y_next = py;
                        if (py > max_y_reg) max_y_next = py;
                        psx_next = psx_reg + DIV_W'(px);
                        psy_next = psy_reg + DIV_W'(py);
                        rc_next  = rc_reg + 1'b1;
                    end

                    if (samp_end)
                    begin
                        div_start = 1'b1;
                        div_a     = DIV_W'(csum_next[0]);
                        div_b     = seen_next;
                        op_next   = OP_BLUE;
                        sq_next   = SQ_DIV;
                    end
                    else if (item.pix.last_pixel)
                    begin
                        if ((phase_reg != PH_REJECTED) && (rc_next != '0))
                        begin
                            div_start = 1'b1;
                            div_a     = psx_next;
                            div_b     = rc_next;
                            op_next   = OP_CX;
                            sq_next   = SQ_DIV;
                        end
                        else
                        begin
                            sq_next = SQ_EMIT;
                        end
                    end
                end
            end

            SQ_DIV:
            begin
                if (div_done)
                begin
                    case (op_reg)
                        OP_BLUE:
                        begin
                            mean_next[0] = COLOR_W'(div_q);
                            div_start    = 1'b1;
                            div_a        = DIV_W'(csum_reg[1]);
                            div_b        = seen_reg;
                            op_next      = OP_GREEN;
                        end
                        OP_GREEN:
                        begin
                            mean_next[1] = COLOR_W'(div_q);
                            div_start    = 1'b1;
                            div_a        = DIV_W'(csum_reg[2]);
                            div_b        = seen_reg;
                            op_next      = OP_RED;
                        end
                        OP_RED:
                        begin
                            mean_next[2] = COLOR_W'(div_q);
                            phase_next   = mean_skin ? PH_TRACKING : PH_REJECTED;
                            if (!emit_reg)
                            begin
                                sq_next = SQ_RUN;
                            end
                            else if (mean_skin && (rc_reg != '0))
                            begin
                                div_start = 1'b1;
                                div_a     = psx_reg;
                                div_b     = rc_reg;
                                op_next   = OP_CX;
                            end
                            else
                            begin
                                sq_next = SQ_EMIT;
                            end
                        end
                        OP_CX:
                        begin
                            cx_next   = POS_W'(div_q);
                            div_start = 1'b1;
                            div_a     = psy_reg;
                            div_b     = rc_reg;
                            op_next   = OP_CY;
                        end
                        OP_CY:
                        begin
                            cy_next = POS_W'(div_q);
                            sq_next = SQ_EMIT;
                        end
                        default:
                        begin
                            sq_next = SQ_EMIT;
                        end
                    endcase
                end
            end

            SQ_EMIT:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '0;
                    if (found)
                    begin
                        out_next.hand_found = 1'b1;
                        out_next.box_x      = POS_W'(min_x_reg);
                        out_next.box_y      = POS_W'(min_y_reg);
                        out_next.box_width  = POS_W'(max_x_reg - min_x_reg);
                        out_next.box_height = POS_W'(max_y_reg - min_y_reg);
                        out_next.center_x   = cx_reg;
                        out_next.center_y   = cy_reg;
                    end
                    out_next.mean_blue  = mean_reg[0];
                    out_next.mean_green = mean_reg[1];
                    out_next.mean_red   = mean_reg[2];
                    // fresh list
                    phase_next = PH_SAMPLING;
                    seen_next  = '0;
                    miss_next  = '0;
                    min_x_next = '1;
                    min_y_next = '1;
                    max_x_next = '0;
                    max_y_next = '0;
                    psx_next   = '0;
                    psy_next   = '0;
                    rc_next    = '0;
                    emit_next  = 1'b0;
                    for (int i = 0; i < 3; i++)
                    begin
                        csum_next[i] = '0;
                        mean_next[i] = '0;
                    end
                    sq_next = SQ_RUN;
                end
            end

            default:
            begin
                sq_next = SQ_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_reg        <= SQ_RUN;
            op_reg        <= OP_BLUE;
            emit_reg      <= 1'b0;
            phase_reg     <= PH_SAMPLING;
            seen_reg      <= '0;
            miss_reg      <= '0;
            min_x_reg     <= '1;
            min_y_reg     <= '1;
            max_x_reg     <= '0;
            max_y_reg     <= '0;
            psx_reg       <= '0;
            psy_reg       <= '0;
            rc_reg        <= '0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                csum_reg[i] <= '0;
                mean_reg[i] <= '0;
            end
        end
        else
        begin
            sq_reg        <= sq_next;
            op_reg        <= op_next;
            emit_reg      <= emit_next;
            phase_reg     <= phase_next;
            seen_reg      <= seen_next;
            miss_reg      <= miss_next;
            min_x_reg     <= min_x_next;
            min_y_reg     <= min_y_next;
            max_x_reg     <= max_x_next;
            max_y_reg     <= max_y_next;
            psx_reg       <= psx_next;
            psy_reg       <= psy_next;
            rc_reg        <= rc_next;
            cx_reg        <= cx_next;
            cy_reg        <= cy_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < 3; i++)
            begin
                csum_reg[i] <= csum_next[i];
                mean_reg[i] <= mean_next[i];
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

// ===== sv/skin_region_box_centroid.sv =====
// Ordinary pixels pass front stage, queue and back end, one pixel per cycle while the back end
// is not dividing or emitting and the queue has room. End of sampling runs three divisions on one
// shared restoring divider; pixels queue meanwhile. The last pixel adds up to two more divisions
// for the centroid, then the result item is registered. Reset (rst_n low, asynchronous) clears
// all list state and loads the register defaults; no clearing pass is needed.
`include "skin_region_box_centroid_defines.svh"
module skin_region_box_centroid import srbc_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    srbc_pix_if.sink          pix_in,
    srbc_res_if.source        res_out
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;
    logic       push;
    logic       pop;
    qitem_t     push_item;
    qitem_t     pop_item;
    qstat_t     qstat;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_count <= SAMPLE_COUNT_RST;
            cfg_reg.miss_limit   <= MISS_LIMIT_RST;
            cfg_reg.red_min      <= RED_MIN_RST;
            cfg_reg.green_min    <= GREEN_MIN_RST;
            cfg_reg.blue_min     <= BLUE_MIN_RST;
            cfg_reg.red_margin   <= RED_MARGIN_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_SAMPLE_COUNT: cfg_reg.sample_count <= pwdata[15:0];
                REG_MISS_LIMIT:   cfg_reg.miss_limit   <= pwdata[7:0];
                REG_RED_MIN:      cfg_reg.red_min      <= pwdata[7:0];
                REG_GREEN_MIN:    cfg_reg.green_min    <= pwdata[7:0];
                REG_BLUE_MIN:     cfg_reg.blue_min     <= pwdata[7:0];
                REG_RED_MARGIN:   cfg_reg.red_margin   <= pwdata[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // register reads
    always_comb
    begin
        case (reg_idx)
            REG_SAMPLE_COUNT: prdata = DATA_W'(cfg_reg.sample_count);
            REG_MISS_LIMIT:   prdata = DATA_W'(cfg_reg.miss_limit);
            REG_RED_MIN:      prdata = DATA_W'(cfg_reg.red_min);
            REG_GREEN_MIN:    prdata = DATA_W'(cfg_reg.green_min);
            REG_BLUE_MIN:     prdata = DATA_W'(cfg_reg.blue_min);
            REG_RED_MARGIN:   prdata = DATA_W'(cfg_reg.red_margin);
            default:          prdata = '0;
        endcase
    end

    srbc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pix       (pix_in),
        .qstat     (qstat),
        .push      (push),
        .push_item (push_item)
    );

    srbc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .stat      (qstat)
    );

    srbc_back #(
        .COORD_BITS (COORD_BITS),
        .MAX_PIXELS (MAX_PIXELS)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .qstat (qstat),
        .item  (pop_item),
        .pop   (pop),
        .res   (res_out)
    );

    // a rejected or empty region reports no box and no centre
    `SRBC_ASSERT_NOW(a_reject_zero, res_out.valid && !res_out.data.hand_found, (res_out.data.box_width == '0) && (res_out.data.center_x == '0) && (res_out.data.box_x == '0), "rejected result carries a box")
    // queue occupancy never passes its depth
    `SRBC_ASSERT_NOW(a_queue_bound, 1'b1, qstat.count <= (QPTR_W+1)'(QUEUE_DEPTH), "queue overfilled")
    // occupancy moves by at most one per cycle
    `SRBC_ASSERT_NEXT(a_queue_step, 1'b1, (qstat.count == $past(qstat.count)) || (qstat.count == $past(qstat.count) + 3'd1) || (qstat.count == $past(qstat.count) - 3'd1), "queue count jumped")

endmodule

// ===== bench/skin_region_box_centroid_tb.sv =====
// Testbench for the skin region box and centroid block: directed and random pixel lists.
module skin_region_box_centroid_tb;
    import srbc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXPIX     = 65535;
    localparam int IDLE_LIMIT = 20000;
    // worst case: three colour divisions plus two centroid divisions, then output
    localparam int DRAIN_CYCLES = 200;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    srbc_pix_if pix_ch ();
    srbc_res_if res_ch ();

    skin_region_box_centroid dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .pix_in  (pix_ch.sink),
        .res_out (res_ch.source)
    );

    // Clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Predictor state: configuration and list state
    cfg_t        cfg_m;
    logic [1:0]  list_phase;
    int unsigned pix_seen;
    int unsigned sum_col [3];
    int unsigned miss_cnt;
    int unsigned lo_x, lo_y, hi_x, hi_y;
    longint unsigned sum_x, sum_y;
    int unsigned reg_cnt;
    int unsigned avg_col [3];

    res_t expected_boxes [$];
    int   error_count = 0;
    int   idle_cycles = 0;
    bit   rx_stall_off;

    function automatic bit skin_test(int unsigned b, int unsigned g, int unsigned r);
        return r > cfg_m.red_min && g > cfg_m.green_min && b > cfg_m.blue_min &&
               r > g + cfg_m.red_margin && r > b + cfg_m.red_margin;
    endfunction

    task automatic clear_list_state();
        list_phase = PH_SAMPLING;
        pix_seen = 0;
        sum_col = '{0, 0, 0};
        miss_cnt = 0;
        lo_x = 4095;
        lo_y = 4095;
        hi_x = 0;
        hi_y = 0;
        sum_x = 0;
        sum_y = 0;
        reg_cnt = 0;
        avg_col = '{0, 0, 0};
    endtask

    task automatic grow_region(int unsigned x, int unsigned y);
        if (reg_cnt < MAXPIX)
        begin
            if (x < lo_x) lo_x = x;
            if (x > hi_x) hi_x = x;
            if (y < lo_y) lo_y = y;
            if (y > hi_y) hi_y = y;
            sum_x += x;
            sum_y += y;
            reg_cnt++;
        end
    endtask

    // Advance the predictor by one pixel; queue a box at the end of a list
    task automatic predict_box(pix_t p);
        int unsigned s_cnt, m_lim;
        res_t r;
        s_cnt = (cfg_m.sample_count == 0) ? 1 : cfg_m.sample_count;
        m_lim = (cfg_m.miss_limit == 0) ? 1 : cfg_m.miss_limit;
        if (list_phase == PH_SAMPLING)
        begin
            sum_col[0] += p.blue;
            sum_col[1] += p.green;
            sum_col[2] += p.red;
            pix_seen++;
            grow_region(p.pos_x, p.pos_y);
            if (pix_seen >= s_cnt || pix_seen >= MAXPIX || p.last_pixel)
            begin
                for (int i = 0; i < 3; i++)
                    avg_col[i] = (sum_col[i] / pix_seen) & 8'hFF;
                list_phase = skin_test(avg_col[0], avg_col[1], avg_col[2]) ?
                             PH_TRACKING : PH_REJECTED;
            end
        end
        else if (list_phase == PH_TRACKING)
        begin
            if (skin_test(p.blue, p.green, p.red))
            begin
                miss_cnt = 0;
                grow_region(p.pos_x, p.pos_y);
            end
            else if (miss_cnt + 1 >= m_lim)
                list_phase = PH_STOPPED;
            else
            begin
                miss_cnt++;
                grow_region(p.pos_x, p.pos_y);
            end
        end
        if (p.last_pixel)
        begin
            r = '0;
            if (list_phase != PH_REJECTED && reg_cnt > 0)
            begin
                r.hand_found = 1'b1;
                r.box_x      = lo_x[11:0];
                r.box_y      = lo_y[11:0];
                r.box_width  = 12'(hi_x - lo_x);
                r.box_height = 12'(hi_y - lo_y);
                r.center_x   = 12'(sum_x / reg_cnt);
                r.center_y   = 12'(sum_y / reg_cnt);
            end
            r.mean_blue  = avg_col[0][7:0];
            r.mean_green = avg_col[1][7:0];
            r.mean_red   = avg_col[2][7:0];
            expected_boxes.push_back(r);
            clear_list_state();
        end
    endtask

    // Gap length: mostly short, a few long
    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 55) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Register write over the APB port
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SAMPLE_COUNT: cfg_m.sample_count = val[15:0];
            REG_MISS_LIMIT:   cfg_m.miss_limit   = val[7:0];
            REG_RED_MIN:      cfg_m.red_min      = val[7:0];
            REG_GREEN_MIN:    cfg_m.green_min    = val[7:0];
            REG_BLUE_MIN:     cfg_m.blue_min     = val[7:0];
            REG_RED_MARGIN:   cfg_m.red_margin   = val[7:0];
            default: ;
        endcase
    endtask

    task automatic set_config(int s_cnt, int m_lim, int rmin, int gmin, int bmin, int rmar);
        write_reg(REG_SAMPLE_COUNT, s_cnt);
        write_reg(REG_MISS_LIMIT, m_lim);
        write_reg(REG_RED_MIN, rmin);
        write_reg(REG_GREEN_MIN, gmin);
        write_reg(REG_BLUE_MIN, bmin);
        write_reg(REG_RED_MARGIN, rmar);
    endtask

    // Send one pixel; predictor is advanced when the item is accepted
    task automatic send_pixel(pix_t p, bit no_gap);
        int g;
        g = no_gap ? 0 : gap_len();
        if (g > 0)
        begin
            pix_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.data  <= p;
        @(posedge clk);
        while (!pix_ch.ready) @(posedge clk);
        predict_box(p);
    endtask

    task automatic idle_source();
        pix_ch.valid <= 1'b0;
    endtask

    // Wait for all boxes, then let the block settle before reconfiguring
    task automatic drain();
        idle_source();
        while (expected_boxes.size() > 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic pix_t make_pixel(int x, int y, int b, int g, int r, bit last);
        pix_t p;
        p.pos_x = POS_W'(x);
        p.pos_y = POS_W'(y);
        p.blue  = COLOR_W'(b);
        p.green = COLOR_W'(g);
        p.red   = COLOR_W'(r);
        p.last_pixel = last;
        return p;
    endfunction

    // Pixel that passes or fails the current skin rule, where possible
    function automatic pix_t rand_colour_pixel(bit want_skin, bit last);
        pix_t p;
        p = make_pixel($urandom_range(0, 4095), $urandom_range(0, 4095),
                       $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255), last);
        for (int t = 0; t < 20; t++)
        begin
            if (skin_test(p.blue, p.green, p.red) == want_skin) break;
            if (want_skin)
            begin
                p.red   = COLOR_W'($urandom_range(150, 255));
                p.green = COLOR_W'($urandom_range(41, 110));
                p.blue  = COLOR_W'($urandom_range(21, 110));
            end
            else
                p.red = COLOR_W'($urandom_range(0, 90));
        end
        return p;
    endfunction

    // Random list: a sampling run, then mostly skin pixels with miss runs
    task automatic send_rand_list(int len);
        int miss_bias;
        pix_t p;
        miss_bias = $urandom_range(0, 40);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                p = make_pixel($urandom, $urandom, $urandom, $urandom, $urandom, 1'b0);
            else
                p = rand_colour_pixel($urandom_range(0, 99) >= miss_bias, 1'b0);
            p.last_pixel = (i == len - 1);
            send_pixel(p, 1'b0);
        end
    endtask

    // Directed: extremes, rejection, short list, stop pixel
    task automatic test_directed();
        set_config(3, 2, 95, 40, 20, 15);
        // rejected list with extreme coordinates
        send_pixel(make_pixel(4095, 4095, 255, 255, 255, 1'b0), 1'b0);
        send_pixel(make_pixel(0, 0, 0, 0, 0, 1'b1), 1'b0);
        // accepted list, two misses then stop and a trailing ignored pixel
        send_pixel(make_pixel(100, 10, 60, 60, 200, 1'b0), 1'b1);
        send_pixel(make_pixel(50, 11, 60, 60, 200, 1'b0), 1'b1);
        send_pixel(make_pixel(300, 12, 60, 60, 200, 1'b0), 1'b1);
        send_pixel(make_pixel(4095, 13, 0, 0, 0, 1'b0), 1'b0);
        send_pixel(make_pixel(0, 4095, 0, 0, 0, 1'b0), 1'b0);
        send_pixel(make_pixel(7, 7, 60, 60, 200, 1'b1), 1'b0);
        // single-pixel list, short of the sample count
        send_pixel(make_pixel(2048, 1024, 30, 50, 255, 1'b1), 1'b0);
        drain();
        // zero registers act as one
        set_config(0, 0, 0, 0, 0, 0);
        send_pixel(make_pixel(1, 2, 1, 1, 3, 1'b0), 1'b0);
        send_pixel(make_pixel(3, 4, 1, 1, 3, 1'b0), 1'b0);
        send_pixel(make_pixel(5, 6, 9, 9, 3, 1'b0), 1'b0);
        send_pixel(make_pixel(9, 9, 1, 1, 3, 1'b1), 1'b0);
        send_pixel(make_pixel(0, 0, 0, 0, 0, 1'b1), 1'b0);
        drain();
        // maximum thresholds: nothing is skin
        set_config(65535, 255, 255, 255, 255, 255);
        send_pixel(make_pixel(4095, 0, 255, 255, 255, 1'b1), 1'b0);
        drain();
    endtask

    // Random lists under a given setting
    task automatic test_random(int lists, int max_len, int s_cnt, int m_lim,
                               int rmin, int gmin, int bmin, int rmar);
        set_config(s_cnt, m_lim, rmin, gmin, bmin, rmar);
        for (int n = 0; n < lists; n++)
            send_rand_list($urandom_range(1, max_len));
        drain();
    endtask

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            res_t e, a;
            a = res_ch.data;
            if (expected_boxes.size() == 0)
            begin
                $error("unexpected result item %p", a);
                error_count++;
            end
            else
            begin
                e = expected_boxes.pop_front();
                if (a.hand_found !== e.hand_found) begin $error("hand_found exp %0d got %0d", e.hand_found, a.hand_found); error_count++; end
                if (a.box_x !== e.box_x) begin $error("box_x exp %0d got %0d", e.box_x, a.box_x); error_count++; end
                if (a.box_y !== e.box_y) begin $error("box_y exp %0d got %0d", e.box_y, a.box_y); error_count++; end
                if (a.box_width !== e.box_width) begin $error("box_width exp %0d got %0d", e.box_width, a.box_width); error_count++; end
                if (a.box_height !== e.box_height) begin $error("box_height exp %0d got %0d", e.box_height, a.box_height); error_count++; end
                if (a.center_x !== e.center_x) begin $error("center_x exp %0d got %0d", e.center_x, a.center_x); error_count++; end
                if (a.center_y !== e.center_y) begin $error("center_y exp %0d got %0d", e.center_y, a.center_y); error_count++; end
                if (a.mean_blue !== e.mean_blue) begin $error("mean_blue exp %0d got %0d", e.mean_blue, a.mean_blue); error_count++; end
                if (a.mean_green !== e.mean_green) begin $error("mean_green exp %0d got %0d", e.mean_green, a.mean_green); error_count++; end
                if (a.mean_red !== e.mean_red) begin $error("mean_red exp %0d got %0d", e.mean_red, a.mean_red); error_count++; end
            end
        end
    end

    // Receiver stalls: mostly short, a few long, some stretches with none
    always @(posedge clk)
    begin
        if (!rst_n || rx_stall_off)
            res_ch.ready <= 1'b1;
        else
            res_ch.ready <= ($urandom_range(0, 99) < 70) ||
                            ($urandom_range(0, 99) < 3 ? 1'b0 : res_ch.ready);
    end

    // Watchdog on cycles with no accepted item
    always @(posedge clk)
    begin
        if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        pix_ch.valid = 1'b0;
        pix_ch.data = '0;
        rx_stall_off = 1'b0;
        cfg_m = {SAMPLE_COUNT_RST, MISS_LIMIT_RST, RED_MIN_RST, GREEN_MIN_RST,
                 BLUE_MIN_RST, RED_MARGIN_RST};
        clear_list_state();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(30, 12, 4, 3, 95, 40, 20, 15);
        test_random(20, 20, 1, 1, 95, 40, 20, 15);
        rx_stall_off = 1'b1;
        test_random(20, 30, 8, 255, 60, 30, 10, 5);
        rx_stall_off = 1'b0;
        test_random(15, 25, 65535, 5, 95, 40, 20, 15);
        test_random(10, 15, 2, 2, 0, 0, 0, 0);
        test_random(10, 15, 3, 4, 255, 255, 255, 255);

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
